@@ sv/cpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants for the circle pair contact core.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

endpackage

@@ sv/cpc_sqrt_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_sqrt_pipe
// Pipelined integer square root, one result bit per register stage.
// A sideband vector and a valid bit travel with each item.
// ----------------------------------------------------------------------------
module cpc_sqrt_pipe #(
    parameter int W      = cpc_pkg::COORD_WIDTH,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*W-1:0]      in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [W-1:0]        out_root,
    output logic [SIDE_W-1:0]   out_side
);

    logic              valid_reg [W];
    logic [2*W-1:0]    rem_reg   [W];
    logic [W-1:0]      root_reg  [W];
    logic [SIDE_W-1:0] side_reg  [W];

    genvar s;
    generate
        for (s = 0; s < W; s++) begin : g_stage
            localparam int K = W - 1 - s;
            logic              v_in;
            logic [2*W-1:0]    rem_in;
            logic [W-1:0]      root_in;
            logic [SIDE_W-1:0] side_in;
            logic [2*W-1:0]    trial;
            logic [2*W-1:0]    rem_next;
            logic [W-1:0]      root_next;

            if (s == 0) begin : g_first
                assign v_in    = in_valid;
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign side_in = in_side;
            end else begin : g_rest
                assign v_in    = valid_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign side_in = side_reg[s-1];
            end

            // (root + 2^k)^2 - root^2 = root * 2^(k+1) + 2^(2k)
            always_comb
            begin
                trial = ({{W{1'b0}}, root_in} << (K + 1))
                        | ({{(2*W-1){1'b0}}, 1'b1} << (2 * K));
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = root_in | ({{(W-1){1'b0}}, 1'b1} << K);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= rem_next;
                    root_reg[s] <= root_next;
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[W-1];
    assign out_root  = root_reg[W-1];
    assign out_side  = side_reg[W-1];

endmodule

@@ sv/cpc_div_pipe.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_div_pipe
// Two-lane pipelined restoring divider sharing one divisor:
// q = floor(num * 2^F / den) with num <= den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cpc_div_pipe #(
    parameter int W      = cpc_pkg::COORD_WIDTH,
    parameter int F      = cpc_pkg::FRAC_BITS,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        num_a,
    input  logic [W-1:0]        num_b,
    input  logic [W-1:0]        den,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [F:0]          quo_a,
    output logic [F:0]          quo_b,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int N = F + 1;

    logic              valid_reg [N];
    logic [W-1:0]      rema_reg  [N];
    logic [W-1:0]      remb_reg  [N];
    logic [W-1:0]      den_reg   [N];
    logic [F:0]        qa_reg    [N];
    logic [F:0]        qb_reg    [N];
    logic [SIDE_W-1:0] side_reg  [N];

    genvar s;
    generate
        for (s = 0; s < N; s++) begin : g_stage
            logic              v_in;
            logic [W:0]        va;
            logic [W:0]        vb;
            logic [W-1:0]      d_in;
            logic [F:0]        qa_in;
            logic [F:0]        qb_in;
            logic [SIDE_W-1:0] side_in;
            logic              ba;
            logic              bb;
            logic [W:0]        ra_next;
            logic [W:0]        rb_next;

            if (s == 0) begin : g_first
                assign v_in    = in_valid;
                assign va      = {1'b0, num_a};
                assign vb      = {1'b0, num_b};
                assign d_in    = den;
                assign qa_in   = '0;
                assign qb_in   = '0;
                assign side_in = in_side;
            end else begin : g_rest
                assign v_in    = valid_reg[s-1];
                assign va      = {rema_reg[s-1], 1'b0};
                assign vb      = {remb_reg[s-1], 1'b0};
                assign d_in    = den_reg[s-1];
                assign qa_in   = qa_reg[s-1];
                assign qb_in   = qb_reg[s-1];
                assign side_in = side_reg[s-1];
            end

            always_comb
            begin
                ba      = (va >= {1'b0, d_in});
                bb      = (vb >= {1'b0, d_in});
                ra_next = ba ? (va - {1'b0, d_in}) : va;
                rb_next = bb ? (vb - {1'b0, d_in}) : vb;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[s] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rema_reg[s] <= ra_next[W-1:0];
                    remb_reg[s] <= rb_next[W-1:0];
                    den_reg[s]  <= d_in;
                    qa_reg[s]   <= {qa_in[F-1:0], ba};
                    qb_reg[s]   <= {qb_in[F-1:0], bb};
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign quo_a     = qa_reg[N-1];
    assign quo_b     = qb_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

@@ sv/circle_pair_contact_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_pair_contact_core
// Contact test and manifold for a pair of circles, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one circle pair per item:
//   centres of circles a and b in signed fixed point, radii unsigned.
//   Output channel out_valid/out_ready carries one contact result per
//   item: colliding flag, unit normal a->b, half depth and contact point.
//   Non-colliding pairs give colliding = 0 and all other fields zero.
// Timing:
//   Three front stages (offset, squares, compare), one square-root stage
//   per result bit, one stage for depth, one divider stage per quotient
//   bit, then reach, product and output stages; every stage is a
//   register slice. Throughput is one item per cycle while out_ready
//   does not stall the pipeline.
// Reset and stalls:
//   Reset clears all stage valid bits; no item is in flight afterwards.
//   When out_valid is high and out_ready is low the whole pipeline holds
//   and in_ready drops, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module circle_pair_contact_core #(
    parameter int COORD_WIDTH = cpc_pkg::COORD_WIDTH,
    parameter int FRAC_BITS   = cpc_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [COORD_WIDTH-1:0]        a_centre_x,
    input  logic [COORD_WIDTH-1:0]        a_centre_y,
    input  logic [COORD_WIDTH-2:0]        a_radius,
    input  logic [COORD_WIDTH-1:0]        b_centre_x,
    input  logic [COORD_WIDTH-1:0]        b_centre_y,
    input  logic [COORD_WIDTH-2:0]        b_radius,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          colliding,
    output logic [FRAC_BITS+1:0]          normal_x,
    output logic [FRAC_BITS+1:0]          normal_y,
    output logic [COORD_WIDTH-2:0]        depth,
    output logic [COORD_WIDTH-1:0]        contact_x,
    output logic [COORD_WIDTH-1:0]        contact_y
);

    localparam int CW = COORD_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = F + 2;
    localparam int PW = NW + CW + 1;
    localparam int SQ_SIDE_W  = 6 * CW + 2;
    localparam int DIV_SIDE_W = 4 * CW + 2;
    localparam logic signed [PW-1:0] TRUNC_BIAS = {{(PW-F){1'b0}}, {F{1'b1}}};

    logic en;

    // ---------------- stage 1: offset and radius sum
    logic                 s1_valid_reg;
    logic signed [CW:0]   s1_dx_reg, s1_dy_reg;
    logic [CW-1:0]        s1_r_reg, s1_ax_reg, s1_ay_reg;
    logic [CW-2:0]        s1_ra_reg;

    // ---------------- stage 2: squares
    logic                 s2_valid_reg;
    logic [CW:0]          s2_mdx, s2_mdy;
    logic [2*CW+1:0]      s2_sqx_reg, s2_sqy_reg;
    logic [2*CW-1:0]      s2_r2_reg;
    logic                 s2_sx_reg, s2_sy_reg;
    logic [CW-1:0]        s2_mdx_reg, s2_mdy_reg, s2_ax_reg, s2_ay_reg, s2_r_reg;
    logic [CW-2:0]        s2_ra_reg;

    // ---------------- stage 3: distance squared and compare
    logic                 s3_valid_reg;
    logic [2*CW+2:0]      s3_d2;
    logic [2*CW-1:0]      s3_rad_reg;
    logic [SQ_SIDE_W-1:0] s3_side_reg;

    // ---------------- square root
    logic                 sq_valid;
    logic [CW-1:0]        sq_dist;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic                 sq_hit, sq_sx, sq_sy;
    logic [CW-1:0]        sq_mdx, sq_mdy, sq_ax, sq_ay, sq_r;
    logic [CW-2:0]        sq_ra;
    logic [CW-1:0]        sq_gap;

    // ---------------- stage 4: depth
    logic                  s4_valid_reg;
    logic [CW-1:0]         s4_dist_reg, s4_mdx_reg, s4_mdy_reg;
    logic [DIV_SIDE_W-1:0] s4_side_reg;

    // ---------------- divider
    logic                  dv_valid;
    logic [F:0]            dv_qx, dv_qy;
    logic [DIV_SIDE_W-1:0] dv_side;
    logic                  dv_hit, dv_sx, dv_sy, dv_zero;
    logic [CW-1:0]         dv_ax, dv_ay;
    logic [CW-2:0]         dv_ra, dv_depth;

    // ---------------- stage 5: normal and reach
    logic                  s5_valid_reg, s5_hit_reg;
    logic signed [NW-1:0]  s5_nx_reg, s5_ny_reg;
    logic signed [NW-1:0]  s5_nx_next, s5_ny_next;
    logic signed [CW:0]    s5_reach_reg;
    logic [CW-1:0]         s5_ax_reg, s5_ay_reg;
    logic [CW-2:0]         s5_depth_reg;

    // ---------------- stage 6: products
    logic                  s6_valid_reg, s6_hit_reg;
    logic signed [PW-1:0]  s6_px_reg, s6_py_reg;
    logic signed [NW-1:0]  s6_nx_reg, s6_ny_reg;
    logic [CW-1:0]         s6_ax_reg, s6_ay_reg;
    logic [CW-2:0]         s6_depth_reg;

    // ---------------- output register
    logic                  out_valid_reg, colliding_reg;
    logic [NW-1:0]         normal_x_reg, normal_y_reg;
    logic [CW-2:0]         depth_reg;
    logic [CW-1:0]         contact_x_reg, contact_y_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // scale product down toward zero, add centre, saturate to the coord range
    function automatic logic [CW-1:0] contact_coord(
        input logic signed [PW-1:0] prod,
        input logic [CW-1:0]        centre
    );
        logic signed [PW-1:0] adj;
        logic signed [PW-1:0] scaled;
        logic signed [CW+3:0] sum;
        logic [CW-1:0]        res;
        adj    = prod[PW-1] ? (prod + TRUNC_BIAS) : prod;
        scaled = adj >>> F;
        sum    = $signed({{4{centre[CW-1]}}, centre}) + $signed(scaled[CW+3:0]);
        if (sum > $signed({5'b0, {(CW-1){1'b1}}}))
            res = {1'b0, {(CW-1){1'b1}}};
        else if (sum < $signed({5'h1f, {(CW-1){1'b0}}}))
            res = {1'b1, {(CW-1){1'b0}}};
        else
            res = sum[CW-1:0];
        return res;
    endfunction

    // ---------------- valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= sq_valid;
            s5_valid_reg  <= dv_valid;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    // ---------------- front stages
    assign s2_mdx = s1_dx_reg[CW] ? (~s1_dx_reg + 1'b1) : s1_dx_reg;
    assign s2_mdy = s1_dy_reg[CW] ? (~s1_dy_reg + 1'b1) : s1_dy_reg;
    assign s3_d2  = {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= $signed({b_centre_x[CW-1], b_centre_x})
                          - $signed({a_centre_x[CW-1], a_centre_x});
            s1_dy_reg  <= $signed({b_centre_y[CW-1], b_centre_y})
                          - $signed({a_centre_y[CW-1], a_centre_y});
            s1_r_reg   <= {1'b0, a_radius} + {1'b0, b_radius};
            s1_ax_reg  <= a_centre_x;
            s1_ay_reg  <= a_centre_y;
            s1_ra_reg  <= a_radius;

            s2_sqx_reg <= s2_mdx * s2_mdx;
            s2_sqy_reg <= s2_mdy * s2_mdy;
            s2_r2_reg  <= s1_r_reg * s1_r_reg;
            s2_sx_reg  <= s1_dx_reg[CW];
            s2_sy_reg  <= s1_dy_reg[CW];
            s2_mdx_reg <= s2_mdx[CW-1:0];
            s2_mdy_reg <= s2_mdy[CW-1:0];
            s2_ax_reg  <= s1_ax_reg;
            s2_ay_reg  <= s1_ay_reg;
            s2_r_reg   <= s1_r_reg;
            s2_ra_reg  <= s1_ra_reg;

            s3_rad_reg  <= s3_d2[2*CW-1:0];
            s3_side_reg <= {(s3_d2 <= {3'b0, s2_r2_reg}), s2_sx_reg, s2_sy_reg,
                            s2_mdx_reg, s2_mdy_reg, s2_ax_reg, s2_ay_reg,
                            s2_ra_reg, s2_r_reg};
        end
    end

    cpc_sqrt_pipe #(
        .W      (CW),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_rad    (s3_rad_reg),
        .in_side   (s3_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_dist),
        .out_side  (sq_side)
    );

    assign {sq_hit, sq_sx, sq_sy, sq_mdx, sq_mdy, sq_ax, sq_ay, sq_ra, sq_r} = sq_side;
    // dist <= r whenever the pair collides
    assign sq_gap = sq_r - sq_dist;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dist_reg <= sq_dist;
            s4_mdx_reg  <= sq_mdx;
            s4_mdy_reg  <= sq_mdy;
            s4_side_reg <= {sq_hit, sq_sx, sq_sy, sq_ax, sq_ay, sq_ra,
                            sq_gap[CW-1:1], (sq_dist == '0)};
        end
    end

    cpc_div_pipe #(
        .W      (CW),
        .F      (F),
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_valid_reg),
        .num_a     (s4_mdx_reg),
        .num_b     (s4_mdy_reg),
        .den       (s4_dist_reg),
        .in_side   (s4_side_reg),
        .out_valid (dv_valid),
        .quo_a     (dv_qx),
        .quo_b     (dv_qy),
        .out_side  (dv_side)
    );

    assign {dv_hit, dv_sx, dv_sy, dv_ax, dv_ay, dv_ra, dv_depth, dv_zero} = dv_side;

    // coincident centres give a zero normal
    always_comb
    begin
        if (dv_zero)
        begin
            s5_nx_next = '0;
            s5_ny_next = '0;
        end
        else
        begin
            s5_nx_next = dv_sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
            s5_ny_next = dv_sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_hit_reg   <= dv_hit;
            s5_nx_reg    <= s5_nx_next;
            s5_ny_reg    <= s5_ny_next;
            s5_reach_reg <= $signed({2'b0, dv_ra}) - $signed({2'b0, dv_depth});
            s5_ax_reg    <= dv_ax;
            s5_ay_reg    <= dv_ay;
            s5_depth_reg <= dv_depth;

            s6_hit_reg   <= s5_hit_reg;
            s6_px_reg    <= s5_nx_reg * s5_reach_reg;
            s6_py_reg    <= s5_ny_reg * s5_reach_reg;
            s6_nx_reg    <= s5_nx_reg;
            s6_ny_reg    <= s5_ny_reg;
            s6_ax_reg    <= s5_ax_reg;
            s6_ay_reg    <= s5_ay_reg;
            s6_depth_reg <= s5_depth_reg;

            colliding_reg <= s6_hit_reg;
            if (s6_hit_reg)
            begin
                normal_x_reg  <= s6_nx_reg;
                normal_y_reg  <= s6_ny_reg;
                depth_reg     <= s6_depth_reg;
                contact_x_reg <= contact_coord(s6_px_reg, s6_ax_reg);
                contact_y_reg <= contact_coord(s6_py_reg, s6_ay_reg);
            end
            else
            begin
                normal_x_reg  <= '0;
                normal_y_reg  <= '0;
                depth_reg     <= '0;
                contact_x_reg <= '0;
                contact_y_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign colliding = colliding_reg;
    assign normal_x  = normal_x_reg;
    assign normal_y  = normal_y_reg;
    assign depth     = depth_reg;
    assign contact_x = contact_x_reg;
    assign contact_y = contact_y_reg;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test for circle_pair_contact_core. A directed table covers the
// touching, separated, coincident and saturating cases, then random circle
// pairs (mostly near each other, some raw bit patterns) follow. The sender
// runs in bursts and the receiver stalls on its own pattern. Every result is
// checked field by field against a typed expectation or a local contact predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          COORD_WIDTH = cpc_pkg::COORD_WIDTH;
    localparam int          FRAC_BITS   = cpc_pkg::FRAC_BITS;
    localparam int          NRM_W    = FRAC_BITS + 2;
    localparam int          RAD_W    = COORD_WIDTH - 1;
    localparam int          N_RANDOM = 1100;
    localparam logic [31:0] ONE      = 32'h0001_0000;
    localparam logic [31:0] MINC     = 32'h8000_0000;
    localparam logic [31:0] MAXC     = 32'h7fff_ffff;
    localparam logic [30:0] MAXR     = 31'h7fff_ffff;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] ax;
        logic [COORD_WIDTH-1:0] ay;
        logic [RAD_W-1:0]       ra;
        logic [COORD_WIDTH-1:0] bx;
        logic [COORD_WIDTH-1:0] by;
        logic [RAD_W-1:0]       rb;
    } pair_t;

    typedef struct packed {
        logic                   coll;
        logic [NRM_W-1:0]       nx;
        logic [NRM_W-1:0]       ny;
        logic [RAD_W-1:0]       dep;
        logic [COORD_WIDTH-1:0] cx;
        logic [COORD_WIDTH-1:0] cy;
    } contact_t;

    typedef struct {
        pair_t    pair;
        bit       typed;
        contact_t want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [COORD_WIDTH-1:0] a_centre_x;
    logic [COORD_WIDTH-1:0] a_centre_y;
    logic [RAD_W-1:0]       a_radius;
    logic [COORD_WIDTH-1:0] b_centre_x;
    logic [COORD_WIDTH-1:0] b_centre_y;
    logic [RAD_W-1:0]       b_radius;
    logic                   out_valid;
    logic                   out_ready;
    logic                   colliding;
    logic [NRM_W-1:0]       normal_x;
    logic [NRM_W-1:0]       normal_y;
    logic [RAD_W-1:0]       depth;
    logic [COORD_WIDTH-1:0] contact_x;
    logic [COORD_WIDTH-1:0] contact_y;

    contact_t pending_contacts[$];
    int       n_errors;
    int       stall_pct;
    int       cycle_cnt;

    circle_pair_contact_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .a_centre_x (a_centre_x),
        .a_centre_y (a_centre_y),
        .a_radius   (a_radius),
        .b_centre_x (b_centre_x),
        .b_centre_y (b_centre_y),
        .b_radius   (b_radius),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .colliding  (colliding),
        .normal_x   (normal_x),
        .normal_y   (normal_y),
        .depth      (depth),
        .contact_x  (contact_x),
        .contact_y  (contact_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // (n * m) / 2^FRAC_BITS, truncated toward zero
    function automatic longint fix_mul(longint n, longint m);
        longint p;
        p = ((n < 0 ? -n : n) * (m < 0 ? -m : m)) >>> FRAC_BITS;
        return ((n < 0) != (m < 0)) ? -p : p;
    endfunction

    function automatic contact_t contact_of(pair_t p);
        contact_t     c;
        longint       ax, ay, dx, dy, r, mx, my, d_len, dep, nx, ny, reach;
        logic [129:0] d2, rr, root, cand;
        ax = longint'($signed(p.ax));
        ay = longint'($signed(p.ay));
        dx = longint'($signed(p.bx)) - ax;
        dy = longint'($signed(p.by)) - ay;
        r  = longint'(p.ra) + longint'(p.rb);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        d2 = 130'(mx) * 130'(mx) + 130'(my) * 130'(my);
        rr = 130'(r) * 130'(r);
        c  = '0;
        if (d2 > rr)
            return c;
        root = '0;
        for (int b = 35; b >= 0; b--)
        begin
            cand = root | (130'(1) << b);
            if (cand * cand <= d2)
                root = cand;
        end
        d_len = longint'(root);
        dep   = (r - d_len) >>> 1;
        nx    = 0;
        ny    = 0;
        if (d_len != 0)
        begin
            nx = (mx <<< FRAC_BITS) / d_len;
            ny = (my <<< FRAC_BITS) / d_len;
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
        end
        reach = longint'(p.ra) - dep;
        c.coll = 1'b1;
        c.nx   = NRM_W'(clamp(nx, NRM_W));
        c.ny   = NRM_W'(clamp(ny, NRM_W));
        c.dep  = (dep > longint'(MAXR)) ? MAXR : RAD_W'(dep);
        c.cx   = COORD_WIDTH'(clamp(ax + fix_mul(nx, reach), COORD_WIDTH));
        c.cy   = COORD_WIDTH'(clamp(ay + fix_mul(ny, reach), COORD_WIDTH));
        return c;
    endfunction

    // one item; valid stays high across back-to-back items
    task automatic send_pair(pair_t p, contact_t want);
        int gap;
        in_valid   <= 1'b1;
        a_centre_x <= p.ax;
        a_centre_y <= p.ay;
        a_radius   <= p.ra;
        b_centre_x <= p.bx;
        b_centre_y <= p.by;
        b_radius   <= p.rb;
        do
            @(posedge clk);
        while (!in_ready);
        pending_contacts.insert(pending_contacts.size(), want);
        // bursts: mostly no gap, now and then a longer one
        gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic pair_t random_pair();
        pair_t  p;
        longint span;
        p.ax = $urandom;
        p.ay = $urandom;
        p.ra = RAD_W'($urandom);
        p.bx = $urandom;
        p.by = $urandom;
        p.rb = RAD_W'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            // nearby circles so that most pairs reach the contact maths
            span = longint'(1) <<< $urandom_range(2, 31);
            p.bx = p.ax + COORD_WIDTH'($urandom_range(0, 32'hffff_ffff) % (2 * span + 1) - span);
            p.by = p.ay + COORD_WIDTH'($urandom_range(0, 32'hffff_ffff) % (2 * span + 1) - span);
            p.ra = RAD_W'(longint'($urandom) % (span + 1));
            p.rb = RAD_W'(longint'($urandom) % (span + 1));
            if ($urandom_range(0, 15) == 0)
                p.bx = p.ax;
            if ($urandom_range(0, 15) == 0)
                p.by = p.ay;
        end
        return p;
    endfunction

    // receiver: stall rate is redrawn periodically by cycle_cnt, sometimes none
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            cycle_cnt <= 0;
            stall_pct <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt % 300 == 0)
                stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        contact_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_contacts.size() == 0)
            begin
                $error("result with nothing outstanding");
                n_errors++;
            end
            else
            begin
                want = pending_contacts.pop_front();
                if (colliding !== want.coll)
                begin
                    $error("colliding: exp %0d got %0d", want.coll, colliding);
                    n_errors++;
                end
                if (normal_x !== want.nx)
                begin
                    $error("normal_x: exp %h got %h", want.nx, normal_x);
                    n_errors++;
                end
                if (normal_y !== want.ny)
                begin
                    $error("normal_y: exp %h got %h", want.ny, normal_y);
                    n_errors++;
                end
                if (depth !== want.dep)
                begin
                    $error("depth: exp %h got %h", want.dep, depth);
                    n_errors++;
                end
                if (contact_x !== want.cx)
                begin
                    $error("contact_x: exp %h got %h", want.cx, contact_x);
                    n_errors++;
                end
                if (contact_y !== want.cy)
                begin
                    $error("contact_y: exp %h got %h", want.cy, contact_y);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        row_t  rows[$];
        row_t  rw;
        pair_t p;
        int    waited;
        n_errors   = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        a_centre_x = '0;
        a_centre_y = '0;
        a_radius   = '0;
        b_centre_x = '0;
        b_centre_y = '0;
        b_radius   = '0;

        // all zero: coincident and touching at once
        rw = '{'{'0, '0, '0, '0, '0, '0}, 1'b1, '{1'b1, '0, '0, '0, '0, '0}};
        rows.insert(rows.size(), rw);
        // coincident at the extremes with largest radii: depth saturates, contact = a
        rw = '{'{MINC, MAXC, MAXR, MINC, MAXC, MAXR}, 1'b1,
               '{1'b1, '0, '0, MAXR, MINC, MAXC}};
        rows.insert(rows.size(), rw);
        // opposite corners, no radius
        rw = '{'{MINC, MINC, '0, MAXC, MAXC, '0}, 1'b1, '0};
        rows.insert(rows.size(), rw);
        // opposite corners, largest radii: still apart
        rw = '{'{MINC, MINC, MAXR, MAXC, MAXC, MAXR}, 1'b1, '0};
        rows.insert(rows.size(), rw);
        // touching along +x
        rw = '{'{'0, '0, ONE[30:0], 2 * ONE, '0, ONE[30:0]}, 1'b1,
               '{1'b1, NRM_W'(ONE), '0, '0, ONE, '0}};
        rows.insert(rows.size(), rw);
        // touching along -y
        rw = '{'{'0, '0, ONE[30:0], '0, -2 * ONE, ONE[30:0]}, 1'b1,
               '{1'b1, '0, -NRM_W'(ONE), '0, '0, -ONE}};
        rows.insert(rows.size(), rw);
        // one lsb past touching
        rw = '{'{'0, '0, ONE[30:0], 2 * ONE + 1, '0, ONE[30:0]}, 1'b1, '0};
        rows.insert(rows.size(), rw);
        // plain overlaps
        rw = '{'{ONE, ONE, 31'(3 * ONE), 2 * ONE, -ONE, ONE[30:0]}, 1'b0, '0};
        rows.insert(rows.size(), rw);
        rw = '{'{-5 * ONE, 7 * ONE, 31'h0004_8000, -3 * ONE, 6 * ONE, 31'h0002_2000},
               1'b0, '0};
        rows.insert(rows.size(), rw);
        // contact point pushed past the top and bottom of the range
        rw = '{'{32'h7fff_0000, '0, MAXR, MAXC, 32'h0000_0100, '0}, 1'b0, '0};
        rows.insert(rows.size(), rw);
        rw = '{'{32'h8001_0000, '0, MAXR, MINC, 32'hffff_ff00, '0}, 1'b0, '0};
        rows.insert(rows.size(), rw);
        rw = '{'{'0, 32'h8000_4000, MAXR, '0, MINC, '0}, 1'b0, '0};
        rows.insert(rows.size(), rw);
        // largest radius around the smallest
        rw = '{'{MAXC, MINC, MAXR, MAXC, MINC, '0}, 1'b0, '0};
        rows.insert(rows.size(), rw);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_pair(rows[i].pair, rows[i].typed ? rows[i].want : contact_of(rows[i].pair));

        // let the pipeline drain completely before the random part
        in_valid <= 1'b0;
        while (pending_contacts.size() != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            p = random_pair();
            send_pair(p, contact_of(p));
        end
        in_valid <= 1'b0;

        waited = 0;
        while (pending_contacts.size() != 0 && waited < 100_000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_contacts.size() != 0)
        begin
            $error("%0d results never arrived", pending_contacts.size());
            n_errors++;
        end
        repeat (COORD_WIDTH + FRAC_BITS + 20) @(posedge clk);

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
